// ===== hw/rtl/fla_pkg.sv =====
// Shared types and codes for the free list address allocator.
package fla_pkg;

	localparam int unsigned FIELD_BITS = 32;

	localparam logic MODE_RESERVE = 1'b0;
	localparam logic MODE_RELEASE = 1'b1;

	localparam logic [1:0] STATUS_OK         = 2'd0;
	localparam logic [1:0] STATUS_ZERO_SIZE  = 2'd1;
	localparam logic [1:0] STATUS_NO_SPACE   = 2'd2;
	localparam logic [1:0] STATUS_TABLE_FULL = 2'd3;

	typedef struct packed {
		logic                  mode;
		logic [FIELD_BITS-1:0] address;
		logic [FIELD_BITS-1:0] size;
	} req_t;

	typedef struct packed {
		logic [FIELD_BITS-1:0] granted_address;
		logic [1:0]            status;
	} rsp_t;

endpackage

// ===== hw/rtl/fla_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module fla_ram #(
	parameter int unsigned WIDTH = 64,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== hw/rtl/free_list_address_allocator_top.sv =====
// First-fit address allocator with a coalescing free table: top level.
//
// A reserve item grants the lowest-addressed free range that fits, splitting it
// when longer, or else takes space from the next-free pointer (status 2 when the
// address space runs out). A release item merges the range with a free range
// ending at its start and one beginning at its end; a range that ends at the
// next-free pointer pulls the pointer back, otherwise it takes a table entry
// (status 3 and the range is dropped when the table is full). Zero size gives
// status 1. The free table lives in one RAM read one entry per cycle; a
// zero-size item skips that scan. The input is stalled while an item is in
// work; a finished result waits in an output register. No clearing pass
// follows reset: entries are gated by valid flops.
module free_list_address_allocator_top #(
	parameter int unsigned FREE_ENTRIES = 16,
	parameter int unsigned ADDR_BITS    = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  fla_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output fla_pkg::rsp_t rsp
);

	import fla_pkg::*;

	localparam int unsigned IDX_BITS = $clog2(FREE_ENTRIES);
	localparam int unsigned CNT_BITS = $clog2(FREE_ENTRIES + 1);

	localparam logic [2:0] ST_IDLE    = 3'd0;
	localparam logic [2:0] ST_SCAN    = 3'd1;
	localparam logic [2:0] ST_RES_FIN = 3'd2;
	localparam logic [2:0] ST_REL_M1  = 3'd3;
	localparam logic [2:0] ST_REL_M2  = 3'd4;
	localparam logic [2:0] ST_REL_FIN = 3'd5;
	localparam logic [2:0] ST_DONE    = 3'd6;

	logic [2:0]              state_q;
	logic [FREE_ENTRIES-1:0] valid_q;
	logic [ADDR_BITS-1:0]    nfa_q;

	logic                    mode_q;
	logic [ADDR_BITS-1:0]    addr_q;
	logic [ADDR_BITS-1:0]    size_q;
	logic [ADDR_BITS-1:0]    end_q;

	logic [CNT_BITS-1:0]     rd_cnt_q;
	logic                    chk_s1;
	logic [IDX_BITS-1:0]     chk_idx_s1;
	logic                    chk_vld_s1;

	logic                    best_found_q;
	logic [IDX_BITS-1:0]     best_idx_q;
	logic [ADDR_BITS-1:0]    best_start_q;
	logic [ADDR_BITS-1:0]    best_len_q;

	logic                    prev_found_q;
	logic [IDX_BITS-1:0]     prev_idx_q;
	logic [ADDR_BITS-1:0]    prev_start_q;
	logic [ADDR_BITS-1:0]    prev_len_q;
	logic                    next_found_q;
	logic [IDX_BITS-1:0]     next_idx_q;
	logic [ADDR_BITS-1:0]    next_len_q;
	logic                    empty_found_q;
	logic [IDX_BITS-1:0]     empty_idx_q;
	logic                    slot_found_q;
	logic [IDX_BITS-1:0]     slot_idx_q;

	logic [ADDR_BITS-1:0]    start_q;
	logic [ADDR_BITS-1:0]    len_q;

	logic [FIELD_BITS-1:0]   pend_addr_q;
	logic [1:0]              pend_status_q;
	logic                    rsp_valid_q;
	rsp_t                    rsp_q;

	logic                    ram_we;
	logic [IDX_BITS-1:0]     ram_waddr;
	logic [2*ADDR_BITS-1:0]  ram_wdata;
	logic [2*ADDR_BITS-1:0]  ram_rdata;
	logic [IDX_BITS-1:0]     ram_raddr;

	logic [ADDR_BITS-1:0]    ent_start;
	logic [ADDR_BITS-1:0]    ent_len;
	logic [ADDR_BITS-1:0]    ent_end;
	logic                    fit_hit;
	logic                    prev_hit;
	logic                    next_hit;
	logic                    scan_last;
	logic [ADDR_BITS-1:0]    rel_end;
	logic                    in_accept;
	logic                    out_free;

	assign ram_raddr = rd_cnt_q[IDX_BITS-1:0];
	assign ent_start = ram_rdata[2*ADDR_BITS-1:ADDR_BITS];
	assign ent_len   = ram_rdata[ADDR_BITS-1:0];
	assign ent_end   = ADDR_BITS'(ent_start + ent_len);
	assign fit_hit   = chk_vld_s1 && (ent_len >= size_q) &&
		(!best_found_q || (ent_start < best_start_q));
	assign prev_hit  = chk_vld_s1 && !prev_found_q && (ent_end == addr_q);
	assign next_hit  = chk_vld_s1 && !prev_hit && !next_found_q && (ent_start == end_q);
	assign scan_last = (rd_cnt_q == CNT_BITS'(FREE_ENTRIES));
	assign rel_end   = ADDR_BITS'(start_q + len_q);
	assign in_accept = req_valid && !req_stall;
	assign out_free  = !rsp_valid_q || !rsp_stall;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = best_idx_q;
		ram_wdata = {ADDR_BITS'(best_start_q + size_q), ADDR_BITS'(best_len_q - size_q)};
		if (state_q == ST_RES_FIN) begin
			ram_we = best_found_q && (best_len_q > size_q);
		end else if (state_q == ST_REL_FIN) begin
			ram_we    = (rel_end != nfa_q) && slot_found_q;
			ram_waddr = slot_idx_q;
			ram_wdata = {start_q, len_q};
		end
	end

	fla_ram #(
		.WIDTH(2 * ADDR_BITS),
		.DEPTH(FREE_ENTRIES)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			valid_q       <= '0;
			nfa_q         <= ADDR_BITS'(1);
			rd_cnt_q      <= '0;
			chk_s1        <= 1'b0;
			best_found_q  <= 1'b0;
			prev_found_q  <= 1'b0;
			next_found_q  <= 1'b0;
			empty_found_q <= 1'b0;
			slot_found_q  <= 1'b0;
			rsp_valid_q   <= 1'b0;
		end else begin
			if (state_q == ST_DONE && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						mode_q        <= req.mode;
						addr_q        <= ADDR_BITS'(req.address);
						size_q        <= ADDR_BITS'(req.size);
						end_q         <= ADDR_BITS'(ADDR_BITS'(req.address) +
							ADDR_BITS'(req.size));
						rd_cnt_q      <= '0;
						chk_s1        <= 1'b0;
						best_found_q  <= 1'b0;
						prev_found_q  <= 1'b0;
						next_found_q  <= 1'b0;
						empty_found_q <= 1'b0;
						if (ADDR_BITS'(req.size) == '0) begin
							pend_addr_q   <= '0;
							pend_status_q <= STATUS_ZERO_SIZE;
							state_q       <= ST_DONE;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					chk_s1     <= !scan_last;
					chk_idx_s1 <= ram_raddr;
					chk_vld_s1 <= valid_q[ram_raddr];
					if (!scan_last) begin
						rd_cnt_q <= rd_cnt_q + CNT_BITS'(1);
					end
					if (chk_s1) begin
						if (mode_q == MODE_RESERVE) begin
							if (fit_hit) begin
								best_found_q <= 1'b1;
								best_idx_q   <= chk_idx_s1;
								best_start_q <= ent_start;
								best_len_q   <= ent_len;
							end
						end else begin
							if (prev_hit) begin
								prev_found_q <= 1'b1;
								prev_idx_q   <= chk_idx_s1;
								prev_start_q <= ent_start;
								prev_len_q   <= ent_len;
							end
							if (next_hit) begin
								next_found_q <= 1'b1;
								next_idx_q   <= chk_idx_s1;
								next_len_q   <= ent_len;
							end
							if (!chk_vld_s1 && !empty_found_q) begin
								empty_found_q <= 1'b1;
								empty_idx_q   <= chk_idx_s1;
							end
						end
					end
					if (scan_last) begin
						state_q <= (mode_q == MODE_RESERVE) ? ST_RES_FIN : ST_REL_M1;
					end
				end
				ST_RES_FIN: begin
					state_q <= ST_DONE;
					if (best_found_q) begin
						if (best_len_q <= size_q) begin
							valid_q[best_idx_q] <= 1'b0;
						end
						pend_addr_q   <= FIELD_BITS'(64'(best_start_q));
						pend_status_q <= STATUS_OK;
					end else if (size_q > ~nfa_q) begin
						pend_addr_q   <= '0;
						pend_status_q <= STATUS_NO_SPACE;
					end else begin
						nfa_q         <= ADDR_BITS'(nfa_q + size_q);
						pend_addr_q   <= FIELD_BITS'(64'(nfa_q));
						pend_status_q <= STATUS_OK;
					end
				end
				ST_REL_M1: begin
					state_q <= ST_REL_M2;
					if (prev_found_q) begin
						start_q             <= prev_start_q;
						len_q               <= ADDR_BITS'(size_q + prev_len_q);
						valid_q[prev_idx_q] <= 1'b0;
						slot_idx_q          <= prev_idx_q;
					end else begin
						start_q    <= addr_q;
						len_q      <= size_q;
						slot_idx_q <= next_found_q ? next_idx_q : empty_idx_q;
					end
					slot_found_q <= prev_found_q || next_found_q || empty_found_q;
				end
				ST_REL_M2: begin
					state_q <= ST_REL_FIN;
					if (next_found_q) begin
						len_q               <= ADDR_BITS'(len_q + next_len_q);
						valid_q[next_idx_q] <= 1'b0;
					end
				end
				ST_REL_FIN: begin
					state_q     <= ST_DONE;
					pend_addr_q <= '0;
					if (rel_end == nfa_q) begin
						nfa_q         <= start_q;
						pend_status_q <= STATUS_OK;
					end else if (!slot_found_q) begin
						pend_status_q <= STATUS_TABLE_FULL;
					end else begin
						valid_q[slot_idx_q] <= 1'b1;
						pend_status_q       <= STATUS_OK;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			rsp_q.granted_address <= pend_addr_q;
			rsp_q.status          <= pend_status_q;
		end
	end

	assign req_stall = (state_q != ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef SYNTHESIS
	a_fail_no_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.status != STATUS_OK) |-> (rsp.granted_address == '0))
		else $error("failed item carries an address");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (rd_cnt_q <= CNT_BITS'(FREE_ENTRIES)))
		else $error("scan counter overran the table");

	a_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_REL_FIN && slot_found_q) |-> !valid_q[slot_idx_q])
		else $error("release would overwrite a live entry");
`endif

endmodule

// ===== dv/fla_grant_checker.sv =====
`timescale 1ns / 1ps
// Free table model for the address allocator; predicts each grant and compares results.
module fla_grant_checker #(
	parameter int unsigned ENTRIES = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	input  logic          req_stall,
	input  fla_pkg::req_t req,
	input  logic          rsp_valid,
	input  logic          rsp_stall,
	input  fla_pkg::rsp_t rsp,
	output int            failures,
	output int            outstanding
);

	localparam int unsigned AW = fla_pkg::FIELD_BITS;

	logic [AW-1:0] span_start [ENTRIES];
	logic [AW-1:0] span_len   [ENTRIES];
	logic          span_free  [ENTRIES];
	logic [AW-1:0] frontier;

	fla_pkg::rsp_t expected_grants [$];
	fla_pkg::rsp_t due;
	int            fail_count;
	int            reported;

	function automatic fla_pkg::rsp_t reserve_range(logic [AW-1:0] size);
		int            pick;
		fla_pkg::rsp_t res;
		pick = -1;
		res.granted_address = '0;
		res.status = fla_pkg::STATUS_OK;
		for (int i = 0; i < ENTRIES; i++) begin
			if (span_free[i] && span_len[i] >= size) begin
				if (pick < 0)
					pick = i;
				else if (span_start[i] < span_start[pick])
					pick = i;
			end
		end
		if (pick >= 0) begin
			res.granted_address = span_start[pick];
			if (span_len[pick] > size) begin
				span_start[pick] = span_start[pick] + size;
				span_len[pick] = span_len[pick] - size;
			end else begin
				span_free[pick] = 1'b0;
			end
		end else if (size > ~frontier) begin
			res.status = fla_pkg::STATUS_NO_SPACE;
		end else begin
			res.granted_address = frontier;
			frontier = frontier + size;
		end
		return res;
	endfunction

	function automatic fla_pkg::rsp_t release_range(logic [AW-1:0] base, logic [AW-1:0] size);
		int            below;
		int            above;
		int            slot;
		logic [AW-1:0] merged_start;
		logic [AW-1:0] merged_len;
		logic [AW-1:0] range_end;
		logic [AW-1:0] span_end;
		logic [AW-1:0] merged_end;
		fla_pkg::rsp_t res;
		below = -1;
		above = -1;
		slot = -1;
		merged_start = base;
		merged_len = size;
		range_end = base + size;
		res.granted_address = '0;
		res.status = fla_pkg::STATUS_OK;
		for (int i = 0; i < ENTRIES; i++) begin
			span_end = span_start[i] + span_len[i];
			if (span_free[i]) begin
				if (below < 0 && span_end == base)
					below = i;
				else if (above < 0 && span_start[i] == range_end)
					above = i;
			end
		end
		if (below >= 0) begin
			merged_start = span_start[below];
			merged_len = merged_len + span_len[below];
			span_free[below] = 1'b0;
			slot = below;
		end
		if (above >= 0) begin
			merged_len = merged_len + span_len[above];
			span_free[above] = 1'b0;
			if (slot < 0)
				slot = above;
		end
		merged_end = merged_start + merged_len;
		if (merged_end == frontier) begin
			frontier = merged_start;
			return res;
		end
		for (int i = 0; i < ENTRIES; i++) begin
			if (slot < 0 && !span_free[i])
				slot = i;
		end
		if (slot < 0) begin
			res.status = fla_pkg::STATUS_TABLE_FULL;
			return res;
		end
		span_start[slot] = merged_start;
		span_len[slot] = merged_len;
		span_free[slot] = 1'b1;
		return res;
	endfunction

	function automatic fla_pkg::rsp_t predict_grant(fla_pkg::req_t item);
		fla_pkg::rsp_t res;
		res.granted_address = '0;
		res.status = fla_pkg::STATUS_ZERO_SIZE;
		if (item.size == '0)
			return res;
		if (item.mode == fla_pkg::MODE_RESERVE)
			return reserve_range(item.size);
		return release_range(item.address, item.size);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ENTRIES; i++) begin
				span_start[i] = '0;
				span_len[i] = '0;
				span_free[i] = 1'b0;
			end
			frontier = AW'(1);
			expected_grants.delete();
			fail_count = 0;
			reported = 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (expected_grants.size() == 0) begin
					fail_count++;
					if (reported < 10) begin
						reported++;
						$display("%0t: unexpected result addr %h status %0d", $realtime,
							rsp.granted_address, rsp.status);
					end
				end else begin
					due = expected_grants.pop_front();
					if (rsp.granted_address !== due.granted_address ||
						rsp.status !== due.status) begin
						fail_count++;
						if (reported < 10) begin
							reported++;
							$display("%0t: expected addr %h status %0d, got addr %h status %0d",
								$realtime, due.granted_address, due.status,
								rsp.granted_address, rsp.status);
						end
					end
				end
			end
			if (req_valid && !req_stall)
				expected_grants.insert(expected_grants.size(), predict_grant(req));
		end
		failures <= fail_count;
		outstanding <= expected_grants.size();
	end

endmodule

// ===== dv/tb_free_list_address_allocator_top.sv =====
`timescale 1ns / 1ps
// Testbench top for the free list address allocator: stimulus, receiver hold-offs and verdict.
module tb_free_list_address_allocator_top;

	localparam int unsigned ENTRIES = 16;
	localparam int unsigned AW = fla_pkg::FIELD_BITS;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 40;
	localparam int HOLD_CYCLES = 300;
	localparam int ITEMS_PER_PHASE = 260;

	typedef struct packed {
		logic [AW-1:0] base;
		logic [AW-1:0] len;
	} span_t;

	logic          clk;
	logic          arst_n;
	logic          req_valid;
	logic          req_stall;
	fla_pkg::req_t req;
	logic          rsp_valid;
	logic          rsp_stall;
	fla_pkg::rsp_t rsp;

	int failures;
	int outstanding;
	int send_idle_pct;
	int recv_idle_pct;
	int holds_asked;
	int cycle_count;
	int reserves_sent;
	int releases_sent;
	int status_seen [4];

	span_t         held_spans [$];
	fla_pkg::req_t accepted_reqs [$];
	fla_pkg::req_t done_req;

	free_list_address_allocator_top #(
		.FREE_ENTRIES(ENTRIES),
		.ADDR_BITS(AW)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	fla_grant_checker #(
		.ENTRIES(ENTRIES)
	) i_checker (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp),
		.failures(failures),
		.outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count, outstanding);
			$display("** free_list_address_allocator_top: FAILED **");
			$finish;
		end
	end

	// receiver: random stalls, plus a long hold-off whenever one is asked for
	initial begin : receiver
		int holds_done;
		holds_done = 0;
		rsp_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (holds_done != holds_asked) begin
				holds_done++;
				rsp_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			rsp_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// track granted ranges so that later releases hit live allocations
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && !rsp_stall && accepted_reqs.size() != 0) begin
				done_req = accepted_reqs.pop_front();
				status_seen[rsp.status]++;
				if (done_req.mode == fla_pkg::MODE_RESERVE && rsp.status == fla_pkg::STATUS_OK)
					held_spans.insert(held_spans.size(),
						span_t'({rsp.granted_address, done_req.size}));
			end
			if (req_valid && !req_stall) begin
				accepted_reqs.insert(accepted_reqs.size(), req);
				if (req.mode == fla_pkg::MODE_RESERVE)
					reserves_sent++;
				else
					releases_sent++;
			end
		end
	end

	task automatic send_item(input logic op, input logic [AW-1:0] base, input logic [AW-1:0] len);
		fla_pkg::req_t item;
		item.mode = op;
		item.address = base;
		item.size = len;
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= item;
		do @(posedge clk); while (req_stall);
	endtask

	task automatic reserve_span(input logic [AW-1:0] len);
		send_item(fla_pkg::MODE_RESERVE, $urandom, len);
	endtask

	task automatic free_span(input logic [AW-1:0] base, input logic [AW-1:0] len);
		send_item(fla_pkg::MODE_RELEASE, base, len);
	endtask

	task automatic wait_drained();
		req_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	// far-apart releases that cannot merge, enough to overflow the table
	task automatic scatter_fill(input int phase);
		logic [AW-1:0] base;
		base = 32'hA000_0000 + phase * 32'h0100_0000;
		for (int k = 0; k < ENTRIES + 2; k++)
			free_span(base + k * 32'h1000, $urandom_range(1, 16));
	endtask

	task automatic random_item();
		int            pick;
		int            idx;
		span_t         s;
		logic [AW-1:0] half;
		pick = $urandom_range(99);
		if (pick < 45) begin
			reserve_span($urandom_range(1, 64));
		end else if (pick < 83 && held_spans.size() != 0) begin
			idx = $urandom_range(held_spans.size() - 1);
			s = held_spans[idx];
			held_spans.delete(idx);
			if (s.len > 1 && $urandom_range(3) == 0) begin
				half = s.len >> 1;
				held_spans.insert(held_spans.size(), span_t'({s.base + half, s.len - half}));
				free_span(s.base, half);
			end else begin
				free_span(s.base, s.len);
			end
		end else if (pick < 93) begin
			if ($urandom_range(24) == 0)
				free_span($urandom, $urandom);
			else
				free_span($urandom, $urandom_range(1, 256));
		end else if (pick < 97) begin
			reserve_span($urandom);
		end else begin
			send_item($urandom_range(1) ? fla_pkg::MODE_RELEASE : fla_pkg::MODE_RESERVE,
				$urandom, '0);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		cycle_count = 0;
		holds_asked = 0;
		reserves_sent = 0;
		releases_sent = 0;
		for (int i = 0; i < 4; i++)
			status_seen[i] = 0;
		send_idle_pct = 15;
		recv_idle_pct = 76;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero size, address space exhaustion and pull-back
		reserve_span('0);
		free_span('1, '0);
		reserve_span('1);
		reserve_span(32'hFFFF_FFFE);
		reserve_span(32'd1);
		free_span(32'd1, 32'hFFFF_FFFE);
		// split, merge below, merge above only, merge both, exact fit
		reserve_span(32'd16);
		reserve_span(32'd16);
		reserve_span(32'd16);
		free_span(32'd1, 32'd16);
		free_span(32'd17, 32'd16);
		free_span(32'd60, 32'd4);
		free_span(32'd49, 32'd11);
		free_span(32'd33, 32'd16);
		reserve_span(32'd8);
		reserve_span(32'd55);
		// range wrapping past the top address, then merged and reused
		free_span(32'hFFFF_FFF0, 32'h20);
		free_span(32'h10, 32'h20);
		reserve_span(32'h40);
		wait_drained();
		held_spans.delete();

		for (int phase = 0; phase < 3; phase++) begin
			if (phase == 1) begin
				send_idle_pct = 76;
				recv_idle_pct = 15;
			end else if (phase == 2) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			holds_asked++;
			scatter_fill(phase);
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				random_item();
				if (n == ITEMS_PER_PHASE / 2)
					wait_drained();
			end
			wait_drained();
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Run covered %0d reserve and %0d release items with %0d receiver hold-offs.",
			reserves_sent, releases_sent, holds_asked);
		$display("Results: ok %0d, zero size %0d, out of space %0d, table full %0d.",
			status_seen[fla_pkg::STATUS_OK], status_seen[fla_pkg::STATUS_ZERO_SIZE],
			status_seen[fla_pkg::STATUS_NO_SPACE], status_seen[fla_pkg::STATUS_TABLE_FULL]);
		if (failures == 0 && outstanding == 0)
			$display("** free_list_address_allocator_top: PASSED **");
		else
			$display("** free_list_address_allocator_top: FAILED **");
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/fla_pkg.sv
hw/rtl/fla_ram.sv
hw/rtl/free_list_address_allocator_top.sv
dv/fla_grant_checker.sv
dv/tb_free_list_address_allocator_top.sv
